// File: rtl/multipart_boundary_splitter_top_assert.svh
// Assertion macros used by the multipart boundary splitter top level.
`ifndef MULTIPART_BOUNDARY_SPLITTER_TOP_ASSERT_SVH
`define MULTIPART_BOUNDARY_SPLITTER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MBS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mbs_pkg.sv
// Shared types and constants of the multipart boundary splitter.
package mbs_pkg;

    // Boundary storage and delimiter geometry.
    localparam int MAX_BOUNDARY = 32;
    localparam int CHAR_IDX_W   = $clog2(MAX_BOUNDARY);
    localparam int IDX_W        = 6;
    localparam int WORD_COUNT   = MAX_BOUNDARY / 8;
    localparam int ADDR_W       = 6;
    localparam int DATA_W       = 64;

    // Characters with a meaning in the body syntax.
    localparam logic [7:0] CHAR_LF     = 8'd10;
    localparam logic [7:0] CHAR_CR     = 8'd13;
    localparam logic [7:0] CHAR_HYPHEN = 8'd45;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_PART_END = 2'd1,
        KIND_BODY_END = 2'd2,
        KIND_ERROR    = 2'd3
    } t_kind;

    // Register indexes (byte address / 8).
    typedef enum logic [2:0] {
        REG_LEN   = 3'd0,
        REG_WORD0 = 3'd1,
        REG_WORD1 = 3'd2,
        REG_WORD2 = 3'd3,
        REG_WORD3 = 3'd4
    } t_reg_idx;

    // Parser states.
    typedef enum logic [3:0] {
        ST_SEEK   = 4'd0,
        ST_DATA   = 4'd1,
        ST_CR     = 4'd2,
        ST_MATCH  = 4'd3,
        ST_FULL   = 4'd4,
        ST_HYPHEN = 4'd5,
        ST_NEXT   = 4'd6,
        ST_END    = 4'd7,
        ST_ERROR  = 4'd8,
        ST_REPLAY = 4'd9
    } t_state;

    // Configuration seen by the parser.
    typedef struct packed {
        logic [IDX_W-1:0]                  len;
        logic [MAX_BOUNDARY-1:0][7:0]      chars;
    } t_cfg;

    // One result item.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic        last;
    } t_result;

    // Result offered by the parser to the output stage.
    typedef struct packed {
        logic    valid;
        t_result res;
    } t_emit;

endpackage

// File: rtl/mbs_ifs.sv
// Valid/ready channel interfaces for body bytes and result items.
interface mbs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface mbs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] data_byte;
    logic       last_of_run;

    modport source (output valid, output result_kind, output data_byte,
                    output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input data_byte,
                    input last_of_run, output ready);
endinterface

// File: rtl/mbs_cfg_regs.sv
// APB register file holding the boundary length and boundary characters.
module mbs_cfg_regs
    import mbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [IDX_W-1:0]                 r_len;
    logic [WORD_COUNT-1:0][DATA_W-1:0] r_words;
    logic                             wr_en;
    t_reg_idx                         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:3]);

    // Register writes in the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= IDX_W'(1);
            r_words <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_LEN:   r_len      <= pwdata[IDX_W-1:0];
                REG_WORD0: r_words[0] <= pwdata;
                REG_WORD1: r_words[1] <= pwdata;
                REG_WORD2: r_words[2] <= pwdata;
                REG_WORD3: r_words[3] <= pwdata;
                default: ;
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        unique case (reg_idx)
            REG_LEN:   prdata = DATA_W'(r_len);
            REG_WORD0: prdata = r_words[0];
            REG_WORD1: prdata = r_words[1];
            REG_WORD2: prdata = r_words[2];
            REG_WORD3: prdata = r_words[3];
            default:   prdata = '0;
        endcase
    end

    assign o_cfg.len   = r_len;
    assign o_cfg.chars = r_words;

endmodule

// File: rtl/mbs_parser.sv
// Input byte register and delimiter parsing state machine.
module mbs_parser
    import mbs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    mbs_in_if.sink i_byte,
    input  t_cfg   i_cfg,
    input  logic   i_out_free,
    output t_emit  o_emit
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [IDX_W-1:0] r_rep;
    logic [IDX_W-1:0] n_rep;

    logic             consume;
    logic             step;
    logic             emit;
    t_result          res;
    logic [7:0]       c;
    logic [IDX_W-1:0] blen_sat;
    logic [IDX_W-1:0] dlen;
    logic [IDX_W-1:0] dlen_p1;
    logic [IDX_W-1:0] idx_p1;
    logic [IDX_W-1:0] k_sel;
    logic [IDX_W-1:0] j_sel;
    logic [7:0]       dch;
    logic             rep_done;

    assign c = r_in_byte;

    // Delimiter length: two hyphens plus the saturated boundary length.
    assign blen_sat = (i_cfg.len > IDX_W'(MAX_BOUNDARY)) ? IDX_W'(MAX_BOUNDARY) : i_cfg.len;
    assign dlen     = blen_sat + IDX_W'(2);
    assign dlen_p1  = dlen + IDX_W'(1);
    assign idx_p1   = r_idx + IDX_W'(1);

    // One delimiter character lookup, shared by matching and replay.
    assign k_sel = (r_state == ST_REPLAY) ? (r_rep - IDX_W'(2)) : r_idx;
    assign j_sel = k_sel - IDX_W'(2);
    always_comb begin
        if (k_sel < IDX_W'(2)) begin
            dch = CHAR_HYPHEN;
        end else if (j_sel < IDX_W'(MAX_BOUNDARY)) begin
            dch = i_cfg.chars[j_sel[CHAR_IDX_W-1:0]];
        end else begin
            dch = 8'd0;
        end
    end

    // Replay ends once CR, LF and every matched delimiter character are out.
    assign rep_done = (r_rep == idx_p1);

    // Next state, match index and replay position.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_rep   = r_rep;
        consume = 1'b1;
        unique case (r_state) inside
            ST_SEEK: begin
                if (r_idx == dlen) begin
                    if (c == CHAR_CR) begin
                        n_idx = idx_p1;
                    end else begin
                        n_state = ST_ERROR;
                        n_idx   = '0;
                    end
                end else if (r_idx == dlen_p1) begin
                    n_state = (c == CHAR_LF) ? ST_DATA : ST_ERROR;
                    n_idx   = '0;
                end else if (r_idx < dlen && c == dch) begin
                    n_idx = idx_p1;
                end else begin
                    n_idx = '0;
                end
            end
            ST_DATA: begin
                if (c == CHAR_CR) begin
                    n_state = ST_CR;
                end
            end
            ST_CR: begin
                if (c == CHAR_LF) begin
                    n_state = ST_MATCH;
                    n_idx   = '0;
                end else if (c != CHAR_CR) begin
                    // Held CR goes out; the byte is handled again as data.
                    n_state = ST_DATA;
                    consume = 1'b0;
                end
            end
            ST_MATCH: begin
                if (r_idx >= dlen) begin
                    n_state = ST_FULL;
                    consume = 1'b0;
                end else if (c != dch) begin
                    n_state = ST_REPLAY;
                    n_rep   = IDX_W'(1);
                    consume = 1'b0;
                end else begin
                    n_idx = idx_p1;
                    if (idx_p1 == dlen) begin
                        n_state = ST_FULL;
                    end
                end
            end
            ST_REPLAY: begin
                consume = 1'b0;
                if (rep_done) begin
                    n_state = ST_DATA;
                    n_idx   = '0;
                end else begin
                    n_rep = r_rep + IDX_W'(1);
                end
            end
            ST_FULL: begin
                if (c == CHAR_HYPHEN) begin
                    n_state = ST_HYPHEN;
                end else if (c == CHAR_CR) begin
                    n_state = ST_NEXT;
                end else begin
                    n_state = ST_ERROR;
                end
                n_idx = '0;
            end
            ST_HYPHEN: begin
                n_state = (c == CHAR_HYPHEN) ? ST_END : ST_ERROR;
            end
            ST_NEXT: begin
                n_state = (c == CHAR_LF) ? ST_DATA : ST_ERROR;
            end
            ST_END, ST_ERROR: begin
                n_state = r_state;
            end
            default: begin
                n_state = ST_ERROR;
            end
        endcase
    end

    // Result produced in this step, if any.
    always_comb begin
        emit     = 1'b0;
        res.kind = KIND_DATA;
        res.data = 8'd0;
        res.last = 1'b1;
        unique case (r_state)
            ST_SEEK: begin
                if ((r_idx == dlen && c != CHAR_CR) || (r_idx == dlen_p1 && c != CHAR_LF)) begin
                    emit     = 1'b1;
                    res.kind = KIND_ERROR;
                end
            end
            ST_DATA: begin
                if (c != CHAR_CR) begin
                    emit     = 1'b1;
                    res.data = c;
                end
            end
            ST_CR: begin
                if (c != CHAR_LF) begin
                    emit     = 1'b1;
                    res.data = CHAR_CR;
                    res.last = (c == CHAR_CR);
                end
            end
            ST_MATCH: begin
                if (r_idx < dlen && c != dch) begin
                    emit     = 1'b1;
                    res.data = CHAR_CR;
                    res.last = 1'b0;
                end
            end
            ST_REPLAY: begin
                emit     = 1'b1;
                res.data = (r_rep == IDX_W'(1)) ? CHAR_LF : dch;
                res.last = rep_done && (c == CHAR_CR);
            end
            ST_FULL: begin
                if (c != CHAR_HYPHEN) begin
                    emit     = 1'b1;
                    res.kind = (c == CHAR_CR) ? KIND_PART_END : KIND_ERROR;
                end
            end
            ST_HYPHEN: begin
                emit     = 1'b1;
                res.kind = (c == CHAR_HYPHEN) ? KIND_BODY_END : KIND_ERROR;
            end
            ST_NEXT: begin
                if (c != CHAR_LF) begin
                    emit     = 1'b1;
                    res.kind = KIND_ERROR;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // A step runs when a byte is held and any result has room to go.
    assign step          = r_in_valid && (!emit || i_out_free);
    assign i_byte.ready  = !r_in_valid || (step && consume);
    assign o_emit.valid  = r_in_valid && emit && i_out_free;
    assign o_emit.res    = res;

    // Input byte register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (step && consume) begin
            r_in_valid <= 1'b0;
        end
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.in_byte;
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SEEK;
            r_idx   <= '0;
            r_rep   <= '0;
        end else if (step) begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_rep   <= n_rep;
        end
    end

endmodule

// File: rtl/mbs_out_stage.sv
// Output register that holds one result item until the receiver takes it.
module mbs_out_stage
    import mbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_emit      i_emit,
    output logic       o_free,
    mbs_out_if.source  o_result
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_result.ready;

    // Load a new item whenever the slot is empty or being emptied.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_emit.valid;
        end
        if (o_free && i_emit.valid) begin
            r_res <= i_emit.res;
        end
    end

    assign o_result.valid       = r_valid;
    assign o_result.result_kind = 2'(r_res.kind);
    assign o_result.data_byte   = r_res.data;
    assign o_result.last_of_run = r_res.last;

endmodule

// File: rtl/multipart_boundary_splitter_top.sv
// Top level of the multipart boundary splitter.
//
// Body bytes arrive on i_byte (valid/ready), one item per byte. Result items
// leave on o_result: a data byte, part end, body end or format error, with
// last_of_run set on the final result caused by one input byte.
// Software sets the boundary over the APB port (64-bit registers at 8*i)
// while the stream is idle.
// From byte accept to result valid, the byte sits in an input register, the
// parser state machine decides in one step, and the result is registered in
// the output register.
// Throughput is one byte per cycle for ordinary data while the receiver takes
// results. A byte that causes more than one result is held in the input
// register while they go out, since the output register takes one item a cycle;
// a failed delimiter match replays CR, LF and the matched characters this way.
// Reset clears both registers' valid flags and puts the parser in preamble
// search with boundary length one. When the receiver stalls, the output
// register holds its item, one more byte waits in the input register, and
// then i_byte.ready drops until the output frees.
module multipart_boundary_splitter_top
    import mbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    mbs_in_if.sink            i_byte,
    mbs_out_if.source         o_result
);

`include "multipart_boundary_splitter_top_assert.svh"

    t_cfg  cfg;
    t_emit emit;
    logic  out_free;

    mbs_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mbs_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (i_byte),
        .i_cfg      (cfg),
        .i_out_free (out_free),
        .o_emit     (emit)
    );

    mbs_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_emit   (emit),
        .o_free   (out_free),
        .o_result (o_result)
    );

    // Only data results carry a byte.
    `MBS_ASSERT_SAME(a_nondata_zero, i_clk, i_rst_n, o_result.valid && o_result.result_kind != 2'(KIND_DATA), o_result.data_byte == 8'd0, "non-data result carries a byte")

    // Part end, body end and errors are always the only result of their byte.
    `MBS_ASSERT_SAME(a_marker_last, i_clk, i_rst_n, o_result.valid && o_result.result_kind != 2'(KIND_DATA), o_result.last_of_run, "marker result not last of run")

    // A run does not pause: after a non-final result is taken, the next follows.
    `MBS_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, o_result.valid && o_result.ready && !o_result.last_of_run, o_result.valid, "gap inside a run of results")

endmodule

// File: sim/tb_multipart_boundary_splitter_top.sv
// Self-checking testbench for the multipart boundary splitter top level.
`timescale 1ns / 100ps

module tb_multipart_boundary_splitter_top
    import mbs_pkg::*;
();

    localparam logic [7:0]  FILLER_BYTE  = 8'h2E;
    localparam logic [7:0]  RESTART_BYTE = 8'h70;
    localparam int unsigned PHASES       = 7;
    localparam int unsigned PHASE_BYTES  = 12;

    // Tracks the parser state and holds the result items still owed by the block.
    class split_scoreboard;
        t_state      state;
        int unsigned idx;
        logic [5:0]  len_reg;
        logic [63:0] words [WORD_COUNT];
        t_result     burst[$];
        t_result     pending_results[$];
        int unsigned errors;

        function new();
            state = ST_SEEK;
            idx = 0;
            len_reg = 6'd1;
            foreach (words[i]) words[i] = '0;
            errors = 0;
        endfunction

        function void set_register(t_reg_idx r, logic [63:0] v);
            if (r == REG_LEN) begin
                len_reg = v[5:0];
            end else begin
                words[r - REG_WORD0] = v;
            end
        endfunction

        // Delimiter length: two hyphens plus the saturated boundary length.
        function int unsigned delim_len();
            int unsigned b;
            b = 32'(len_reg);
            if (b > MAX_BOUNDARY) b = MAX_BOUNDARY;
            return b + 2;
        endfunction

        function logic [7:0] delim_char(int unsigned k);
            int unsigned j;
            if (k < 2) return CHAR_HYPHEN;
            j = k - 2;
            if (j >= MAX_BOUNDARY) return 8'h00;
            return words[j / 8][(j % 8) * 8 +: 8];
        endfunction

        function void emit(t_kind k, logic [7:0] d);
            burst.push_back('{kind: k, data: d, last: 1'b0});
        endfunction

        // Works out the result items that one accepted body byte causes.
        function void note_body_byte(logic [7:0] c);
            int unsigned dlen;
            bit again;
            t_result r;
            dlen = delim_len();
            burst.delete();
            again = 1'b1;
            while (again) begin
                again = 1'b0;
                case (state) inside
                    ST_SEEK: begin
                        if (idx == dlen) begin
                            if (c == CHAR_CR) begin
                                idx++;
                            end else begin
                                emit(KIND_ERROR, 8'h00);
                                state = ST_ERROR;
                                idx = 0;
                            end
                        end else if (idx == dlen + 1) begin
                            if (c == CHAR_LF) begin
                                state = ST_DATA;
                            end else begin
                                emit(KIND_ERROR, 8'h00);
                                state = ST_ERROR;
                            end
                            idx = 0;
                        end else if (idx < dlen && c == delim_char(idx)) begin
                            idx++;
                        end else begin
                            idx = 0;
                        end
                    end
                    ST_DATA: begin
                        if (c == CHAR_CR) state = ST_CR;
                        else emit(KIND_DATA, c);
                    end
                    ST_CR: begin
                        if (c == CHAR_LF) begin
                            state = ST_MATCH;
                            idx = 0;
                        end else begin
                            emit(KIND_DATA, CHAR_CR);
                            state = ST_DATA;
                            again = 1'b1;
                        end
                    end
                    ST_MATCH: begin
                        if (idx >= dlen) begin
                            state = ST_FULL;
                            again = 1'b1;
                        end else if (c != delim_char(idx)) begin
                            // The held CR LF and the matched prefix go out as data.
                            emit(KIND_DATA, CHAR_CR);
                            emit(KIND_DATA, CHAR_LF);
                            for (int unsigned k = 0; k < idx; k++) emit(KIND_DATA, delim_char(k));
                            state = ST_DATA;
                            idx = 0;
                            again = 1'b1;
                        end else begin
                            idx++;
                            if (idx == dlen) state = ST_FULL;
                        end
                    end
                    ST_FULL: begin
                        if (c == CHAR_HYPHEN) begin
                            state = ST_HYPHEN;
                        end else if (c == CHAR_CR) begin
                            emit(KIND_PART_END, 8'h00);
                            state = ST_NEXT;
                        end else begin
                            emit(KIND_ERROR, 8'h00);
                            state = ST_ERROR;
                        end
                        idx = 0;
                    end
                    ST_HYPHEN: begin
                        if (c == CHAR_HYPHEN) begin
                            emit(KIND_BODY_END, 8'h00);
                            state = ST_END;
                        end else begin
                            emit(KIND_ERROR, 8'h00);
                            state = ST_ERROR;
                        end
                    end
                    ST_NEXT: begin
                        if (c == CHAR_LF) begin
                            state = ST_DATA;
                        end else begin
                            emit(KIND_ERROR, 8'h00);
                            state = ST_ERROR;
                        end
                    end
                    ST_END, ST_ERROR: begin
                    end
                    default: state = ST_ERROR;
                endcase
            end
            foreach (burst[i]) begin
                r = burst[i];
                r.last = (i == burst.size() - 1);
                pending_results.push_back(r);
            end
        endfunction

        // Compares one accepted result item with the oldest one owed.
        function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("result item with none expected: kind %0d data 0x%02h last %0b",
                       kind, data, last);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (kind !== want.kind) begin
                $error("result_kind: expected %0d, actual %0d", want.kind, kind);
                errors++;
            end
            if (data !== want.data) begin
                $error("data_byte: expected 0x%02h, actual 0x%02h", want.data, data);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_of_run: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    mbs_in_if  byte_if ();
    mbs_out_if result_if ();

    split_scoreboard sb;
    logic [7:0]      last_sent;
    logic [7:0]      prior_sent;
    int unsigned     sent_count;
    bit              source_steady;
    bit              sink_steady;
    int unsigned     stall_left;

    multipart_boundary_splitter_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_byte   (byte_if),
        .o_result (result_if)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Mostly short idle spans, now and then a long one.
    function automatic int unsigned idle_span();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] other_than(logic [7:0] avoid);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == avoid) b = b ^ 8'h01;
        return b;
    endfunction

    function automatic logic [7:0] pick_letter();
        return 8'($urandom_range(8'h41, 8'h5A));
    endfunction

    // Random part content, rich in CR, LF and hyphens. A hyphen never directly
    // follows CR LF here, so no delimiter is started by accident.
    function automatic logic [7:0] pick_data_byte();
        logic [7:0] b;
        case ($urandom_range(0, 15))
            0, 1: b = CHAR_CR;
            2: b = CHAR_LF;
            3: b = CHAR_HYPHEN;
            default: b = 8'($urandom_range(0, 255));
        endcase
        if (b == CHAR_HYPHEN && prior_sent == CHAR_CR && last_sent == CHAR_LF) b = FILLER_BYTE;
        return b;
    endfunction

    function automatic logic [7:0] pick_boundary_char();
        if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h30, 8'h7A));
    endfunction

    // Offers one body byte, after a random gap, and waits until it is taken.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = (!source_steady && $urandom_range(0, 3) == 0) ? idle_span() : 0;
        if (gap != 0) begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_if.valid <= 1'b1;
        byte_if.in_byte <= b;
        do @(posedge i_clk); while (!byte_if.ready);
        prior_sent = last_sent;
        last_sent = b;
        sent_count++;
    endtask

    // APB write: setup phase, access phase until pready, then idle.
    task automatic write_reg(input t_reg_idx r, input logic [63:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 3'b000};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(r, v);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stops the byte stream and waits until every owed item is out and the
    // pipeline has emptied.
    task automatic settle();
        byte_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_boundary(input logic [5:0] len_value);
        logic [63:0] word;
        for (int w = 0; w < WORD_COUNT; w++) begin
            for (int b = 0; b < 8; b++) word[b * 8 +: 8] = pick_boundary_char();
            write_reg(t_reg_idx'(REG_WORD0 + w), word);
        end
        write_reg(REG_LEN, {58'd0, len_value});
    endtask

    // CR LF and the full delimiter for the current boundary.
    task automatic send_delimiter();
        int unsigned dlen;
        dlen = sb.delim_len();
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        for (int unsigned j = 0; j < dlen; j++) send_byte(sb.delim_char(j));
    endtask

    // CR LF, part of the delimiter, then a byte that breaks the match.
    task automatic send_false_delimiter();
        int unsigned dlen;
        int unsigned k;
        dlen = sb.delim_len();
        k = ($urandom_range(0, 3) == 0) ? dlen - 1 : $urandom_range(0, dlen - 1);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        for (int unsigned j = 0; j < k; j++) send_byte(sb.delim_char(j));
        send_byte(other_than(sb.delim_char(k)));
    endtask

    // After a boundary change, brings the parser back into part data from
    // wherever the stream stopped, by the rules of the new boundary.
    task automatic resync();
        int unsigned dlen;
        int unsigned k;
        dlen = sb.delim_len();
        k = sb.idx;
        case (sb.state)
            ST_SEEK: begin
                if (k > dlen + 1) begin
                    send_byte(RESTART_BYTE);
                    k = 0;
                end
                for (int unsigned j = k; j < dlen; j++) send_byte(sb.delim_char(j));
                if (k <= dlen) send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            ST_MATCH: begin
                if (k < dlen && $urandom_range(0, 1) == 0) begin
                    send_byte(other_than(sb.delim_char(k)));
                end else begin
                    for (int unsigned j = k; j < dlen; j++) send_byte(sb.delim_char(j));
                    send_byte(CHAR_CR);
                    send_byte(CHAR_LF);
                end
            end
            ST_FULL: begin
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            ST_NEXT: send_byte(CHAR_LF);
            default: begin
            end
        endcase
    endtask

    // Both sides of every handshake are sampled here, before this edge's updates.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (byte_if.valid && byte_if.ready) sb.note_body_byte(byte_if.in_byte);
            if (result_if.valid && result_if.ready) begin
                sb.check_result(result_if.result_kind, result_if.data_byte,
                                result_if.last_of_run);
            end
        end
    end

    // Receiver stalls, with stretches of steady acceptance.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) sink_steady = !sink_steady;
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            result_if.ready <= 1'b0;
        end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
            stall_left = idle_span() - 1;
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= 1'b1;
        end
    end

    initial begin
        #(50_000_000);
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [7:0]  preamble [7];
        logic [7:0]  opening [9];
        bit          early_fault;
        int unsigned stop;
        int unsigned pick;
        int unsigned dlen;
        int unsigned k;
        logic [5:0]  len_value;

        preamble = '{8'h61, CHAR_HYPHEN, CHAR_HYPHEN, CHAR_HYPHEN,
                     CHAR_HYPHEN, CHAR_HYPHEN, 8'h00};
        opening = '{8'h00, 8'hFF, CHAR_CR, 8'h78, CHAR_CR, CHAR_CR,
                    CHAR_LF, CHAR_HYPHEN, 8'h71};
        sb = new();
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        byte_if.valid = 1'b0;
        byte_if.in_byte = 8'h00;
        result_if.ready = 1'b0;
        last_sent = 8'h00;
        prior_sent = 8'h00;
        sent_count = 0;
        source_steady = 1'b0;
        sink_steady = 1'b0;
        stall_left = 0;
        early_fault = ($urandom_range(0, 11) == 0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Preamble under the reset boundary (one NUL character). The third
        // hyphen breaks the first match and is not compared again.
        foreach (preamble[i]) send_byte(preamble[i]);
        if (early_fault && $urandom_range(0, 1) == 0) begin
            // No CR after the first delimiter.
            send_byte(pick_letter());
        end else begin
            send_byte(CHAR_CR);
            // No LF after the CR of the first delimiter.
            if (early_fault) send_byte(pick_letter());
        end

        // Zero-length boundary while the preamble match sits past its end:
        // the search restarts and the bare "--" delimiter opens the body.
        settle();
        write_reg(REG_LEN, 64'd0);
        resync();

        // Byte extremes, a lone CR, CR CR LF, and a failed one-hyphen match.
        foreach (opening[i]) send_byte(opening[i]);
        send_delimiter();
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);

        // Random parts under a new boundary per phase; a phase may stop in the
        // middle of a delimiter so the next boundary takes over the match.
        for (int unsigned p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: len_value = 6'd0;
                1: len_value = 6'd32;
                2: len_value = 6'd63;
                3: len_value = 6'($urandom_range(2, 31));
                4: len_value = 6'd1;
                5: len_value = 6'd40;
                default: len_value = 6'($urandom_range(1, 31));
            endcase
            load_boundary(len_value);
            source_steady = ($urandom_range(0, 3) == 0);
            resync();
            stop = sent_count + PHASE_BYTES;
            while (sent_count < stop) begin
                pick = $urandom_range(0, 19);
                if (pick < 14) begin
                    send_byte(pick_data_byte());
                end else if (pick < 17) begin
                    send_false_delimiter();
                end else begin
                    send_delimiter();
                    send_byte(CHAR_CR);
                    send_byte(CHAR_LF);
                end
            end
            if ($urandom_range(0, 2) == 0) begin
                dlen = sb.delim_len();
                k = $urandom_range(0, dlen);
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
                for (int unsigned j = 0; j < k; j++) send_byte(sb.delim_char(j));
            end
        end

        // Close the body, cleanly or with one of the post-delimiter faults,
        // then show that later bytes are ignored.
        settle();
        resync();
        send_delimiter();
        case ($urandom_range(0, 3))
            0: begin
                send_byte(CHAR_HYPHEN);
                send_byte(CHAR_HYPHEN);
            end
            1: send_byte(pick_letter());
            2: begin
                send_byte(CHAR_HYPHEN);
                send_byte(pick_letter());
            end
            default: begin
                send_byte(CHAR_CR);
                send_byte(pick_letter());
            end
        endcase
        repeat (4) send_byte(8'($urandom_range(0, 255)));

        byte_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
        repeat (8) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: multipart_boundary_splitter_top.f
+incdir+rtl
rtl/mbs_pkg.sv
rtl/mbs_ifs.sv
rtl/mbs_cfg_regs.sv
rtl/mbs_parser.sv
rtl/mbs_out_stage.sv
rtl/multipart_boundary_splitter_top.sv
sim/tb_multipart_boundary_splitter_top.sv
